FILE: hdl/u2u8_pkg.sv
// ----------------------------------------------------------------------------
// u2u8_pkg
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// ----------------------------------------------------------------------------
package u2u8_pkg;

	localparam logic [15:0] UNIT_BOM       = 16'hFEFF;
	localparam logic [15:0] UNIT_BOM_SWAP  = 16'hFFFE;
	localparam logic [15:0] UNIT_ASCII_LIM = 16'h0080;
	localparam logic [15:0] UNIT_TWO_MAX   = 16'h07FF;
	localparam logic [15:0] UNIT_HI_MIN    = 16'hD800;
	localparam logic [15:0] UNIT_HI_MAX    = 16'hDBFF;
	localparam logic [20:0] SUPP_BASE      = 21'h10000;

	localparam logic [7:0] LEAD4 = 8'hF0;
	localparam logic [7:0] LEAD3 = 8'hE0;
	localparam logic [7:0] LEAD2 = 8'hC0;
	localparam logic [7:0] CONT  = 8'h80;

	localparam int unsigned QDEPTH = 2;

	typedef enum logic [1:0] {
		MODE_LE         = 2'd0,
		MODE_BE         = 2'd1,
		MODE_DETECT     = 2'd2,
		MODE_DETECT_ALT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DANGLING = 2'd1,
		ST_REJECT   = 2'd2
	} status_t;

	// one decoded unit: up to four result transfers
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            byte_valid;
		logic            eos;
		status_t         status;
	} job_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic valid;
		job_t job;
	} qhead_t;

endpackage

FILE: hdl/u2u8_front.sv
// ----------------------------------------------------------------------------
// u2u8_front
// Accepts code units, tracks string state and builds at most one job per unit.
// ----------------------------------------------------------------------------
module u2u8_front
	import u2u8_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        accept,
	input  logic [15:0] code_unit,
	input  logic        last_unit,
	output logic        enq,
	output job_t        job
);

	logic [1:0] mode_q;
	logic       at_start_q;
	logic       swap_q;
	logic       hp_q;
	logic [9:0] hb_q;
	logic       rej_q;

	logic        swap_n;
	logic        rej_n;
	logic        hp_n;
	logic [9:0]  hb_n;
	logic [15:0] u;
	logic        skip;
	logic        hp_in;
	logic [2:0]  nres;
	logic [20:0] cp;

	always_comb begin
		if (at_start_q) begin
			if (mode_q == MODE_LE) begin
				swap_n = 1'b0;
				rej_n  = 1'b0;
			end else if (mode_q == MODE_BE) begin
				swap_n = 1'b1;
				rej_n  = 1'b0;
			end else begin
				swap_n = (code_unit == UNIT_BOM_SWAP);
				rej_n  = (code_unit != UNIT_BOM) && (code_unit != UNIT_BOM_SWAP);
			end
		end else begin
			swap_n = swap_q;
			rej_n  = rej_q;
		end
		u     = swap_n ? {code_unit[7:0], code_unit[15:8]} : code_unit;
		skip  = at_start_q && (u == UNIT_BOM);
		hp_in = at_start_q ? 1'b0 : hp_q;
		cp    = SUPP_BASE + {1'b0, hb_q, u[9:0]};

		hp_n = hp_in;
		hb_n = hb_q;
		nres = 3'd0;
		job  = '0;
		job.byte_valid = 1'b1;
		job.status     = ST_OK;

		if (rej_n || skip) begin
			nres = 3'd0;
		end else if (hp_in) begin
			hp_n = 1'b0;
			nres = 3'd4;
			job.bytes[0] = LEAD4 | {5'b0, cp[20:18]};
			job.bytes[1] = CONT | {2'b0, cp[17:12]};
			job.bytes[2] = CONT | {2'b0, cp[11:6]};
			job.bytes[3] = CONT | {2'b0, cp[5:0]};
		end else if (u < UNIT_ASCII_LIM) begin
			nres = 3'd1;
			job.bytes[0] = u[7:0];
		end else if (u <= UNIT_TWO_MAX) begin
			nres = 3'd2;
			job.bytes[0] = LEAD2 | {3'b0, u[10:6]};
			job.bytes[1] = CONT | {2'b0, u[5:0]};
		end else if (u >= UNIT_HI_MIN && u <= UNIT_HI_MAX) begin
			hp_n = 1'b1;
			hb_n = u[9:0];
		end else begin
			nres = 3'd3;
			job.bytes[0] = LEAD3 | {4'b0, u[15:12]};
			job.bytes[1] = CONT | {2'b0, u[11:6]};
			job.bytes[2] = CONT | {2'b0, u[5:0]};
		end

		job.eos = last_unit;
		if (last_unit && nres == 3'd0) begin
			nres           = 3'd1;
			job.byte_valid = 1'b0;
			if (rej_n) begin
				job.status = ST_REJECT;
			end else if (hp_n) begin
				job.status = ST_DANGLING;
			end
		end
		job.last_idx = 2'(nres - 3'd1);
		enq          = accept && (nres != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_LE;
			at_start_q <= 1'b1;
			swap_q     <= 1'b0;
			hp_q       <= 1'b0;
			hb_q       <= '0;
			rej_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (accept) begin
				at_start_q <= last_unit;
				swap_q     <= swap_n;
				hp_q       <= hp_n && !last_unit;
				hb_q       <= hb_n;
				rej_q      <= rej_n && !last_unit;
			end
		end
	end

endmodule

FILE: hdl/u2u8_jobq.sv
// ----------------------------------------------------------------------------
// u2u8_jobq
// Two-entry job queue between the front end and the byte serializer.
// ----------------------------------------------------------------------------
module u2u8_jobq
	import u2u8_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   enq,
	input  job_t   enq_job,
	input  logic   deq,
	output logic   q_full,
	output qhead_t head
);

	job_t       mem_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign q_full     = (count_q == 2'(QDEPTH));
	assign head.valid = (count_q != 2'd0);
	assign head.job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= enq_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (enq && !deq) begin
				count_q <= count_q + 2'd1;
			end else if (deq && !enq) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: hdl/u2u8_back.sv
// ----------------------------------------------------------------------------
// u2u8_back
// Walks the head job byte by byte into the output register.
// ----------------------------------------------------------------------------
module u2u8_back
	import u2u8_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  qhead_t     head,
	output logic       deq,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] utf8_byte,
	output logic       byte_valid,
	output logic       last_of_run,
	output logic       end_of_string,
	output logic [1:0] status
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       bv_q;
	logic       lor_q;
	logic       eos_q;
	status_t    status_q;

	logic advance;
	logic load;
	logic at_end;

	assign advance = !out_valid_q || pop;
	assign load    = advance && head.valid;
	assign at_end  = (idx_q == head.job.last_idx);
	assign deq     = load && at_end;

	assign empty         = !out_valid_q;
	assign utf8_byte     = byte_q;
	assign byte_valid    = bv_q;
	assign last_of_run   = lor_q;
	assign end_of_string = eos_q;
	assign status        = status_q;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= head.job.bytes[idx_q];
			bv_q     <= head.job.byte_valid;
			lor_q    <= at_end;
			eos_q    <= at_end && head.job.eos;
			status_q <= at_end ? head.job.status : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= head.valid;
			end
			if (load) begin
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

endmodule

FILE: hdl/utf16_to_utf8_encoder_unit.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_unit
// UTF-16 code unit stream in, UTF-8 byte stream out.
// ----------------------------------------------------------------------------
// Input queue side: drive code_unit/last_unit with push; a transfer happens
// when push is high and full is low. Output queue side: the oldest result
// sits on utf8_byte/byte_valid/last_of_run/end_of_string/status while empty
// is low; pop takes it. cfg_we/cfg_wdata write the byte order mode
// (0 little endian, 1 swapped, 2 or 3 detect from the leading mark); the
// mode is latched at the first unit of each string.
// The first result of a unit is registered in the job queue and then in
// the output register. Throughput: one result per cycle on the output side
// while the receiver pops; a unit yields 0 to 4 results (a surrogate pair
// gives 4), so sustained input rate is bounded by its result count, set by
// the byte-wide output register. A two-entry job queue decouples the sides:
// input keeps flowing until two decoded units wait behind a stalled output.
// Reset: mode 0, queue and output empty, next unit starts a string.
// A stalled receiver holds the current result; full rises once queue fills.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_unit
	import u2u8_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [15:0] code_unit,
	input  logic        last_unit,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  utf8_byte,
	output logic        byte_valid,
	output logic        last_of_run,
	output logic        end_of_string,
	output logic [1:0]  status
);

	logic   accept;
	logic   enq;
	job_t   enq_job;
	logic   deq;
	logic   q_full;
	qhead_t head;

	assign full   = q_full;
	assign accept = push && !q_full;

	u2u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.code_unit (code_unit),
		.last_unit (last_unit),
		.enq       (enq),
		.job       (enq_job)
	);

	u2u8_jobq u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.enq     (enq),
		.enq_job (enq_job),
		.deq     (deq),
		.q_full  (q_full),
		.head    (head)
	);

	u2u8_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.deq           (deq),
		.pop           (pop),
		.empty         (empty),
		.utf8_byte     (utf8_byte),
		.byte_valid    (byte_valid),
		.last_of_run   (last_of_run),
		.end_of_string (end_of_string),
		.status        (status)
	);

	a_status_eos: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |-> end_of_string)
		else $error("nonzero status away from end of string");

	a_eos_lor: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && end_of_string) |-> last_of_run)
		else $error("end of string not on last result of unit");

	a_bare_item: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !byte_valid) |-> (end_of_string && utf8_byte == 8'h00))
		else $error("bare status item in mid-string");

	a_deq_head: assert property (@(posedge clk) disable iff (!arst_n)
		deq |-> head.valid)
		else $error("dequeue from empty job queue");

endmodule
